[hdl/pft_pkg.sv]
// ---------------------------------------------------------------------------
// pft_pkg: shared types and constants of the PNG flow packet tracker
// Field widths, codes, match patterns and the flow entry type.
// ---------------------------------------------------------------------------
package pft_pkg;

   localparam int FLOW_ENTRIES    = 8;
   localparam int MAX_FRAME_BYTES = 65536;
   localparam int FLOW_IDX_W      = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
   localparam int FLOW_CNT_W      = $clog2(FLOW_ENTRIES + 1);
   localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

   localparam logic [15:0] ETH_BYTES = 16'd14;
   localparam logic [6:0]  MIN_HDR   = 7'd20;

   localparam logic [15:0] SEQ_STEP_RESET    = 16'd1448;
   localparam logic [15:0] MIN_PAYLOAD_RESET = 16'd32;

   localparam logic [3:0] SIG_LEN    = 4'd8;
   localparam logic [3:0] SIG_FAILED = 4'd15;
   localparam logic [2:0] HTTP_LEN   = 3'd6;

   typedef enum logic [0:0] {
      CSR_SEQ_STEP    = 1'b0,
      CSR_MIN_PAYLOAD = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_BAD_IP    = 3'd0,
      ST_BAD_TCP   = 3'd1,
      ST_TOO_SMALL = 3'd2,
      ST_UNTRACKED = 3'd3,
      ST_SEQ_MISS  = 3'd4,
      ST_WRITE     = 3'd5
   } status_type;

   typedef struct packed {
      logic [31:0] ack;
      logic [31:0] next_seq;
      logic [31:0] id;
   } flow_entry_type;

   // per-frame command given to every cell of the table at frame end
   typedef struct packed {
      logic        open;        // append a new entry at the tail
      logic        adv;         // advance next_seq of the hit entry
      logic        del;         // remove the hit entry
      flow_entry_type new_entry;
      logic [15:0] step;
   } flow_cmd_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        sig_rejected;
      logic        flow_started;
      logic        table_full;
      logic        flow_ended;
      logic [31:0] file_id;
      logic [15:0] write_offset;
      logic [15:0] write_length;
   } rsp_word_type;

   function automatic logic [7:0] sig_byte(input logic [2:0] i);
      logic [7:0] r;
      case (i)
         3'd0:    r = 8'h89;
         3'd1:    r = 8'h50;
         3'd2:    r = 8'h4e;
         3'd3:    r = 8'h47;
         3'd4:    r = 8'h0d;
         3'd5:    r = 8'h0a;
         3'd6:    r = 8'h1a;
         default: r = 8'h0a;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] http_byte(input logic [2:0] i);
      logic [7:0] r;
      case (i)
         3'd0:    r = 8'h48;
         3'd1:    r = 8'h54;
         3'd2:    r = 8'h54;
         3'd3:    r = 8'h50;
         3'd4:    r = 8'h2f;
         default: r = 8'h31;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] iend_byte(input logic [1:0] i);
      logic [7:0] r;
      case (i)
         2'd0:    r = 8'h49;
         2'd1:    r = 8'h45;
         2'd2:    r = 8'h4e;
         default: r = 8'h44;
      endcase
      return r;
   endfunction

endpackage

[hdl/pft_stream_if.sv]
// ---------------------------------------------------------------------------
// pft_stream_if: valid/ready channel
// Carries one word of a generic payload type per accepted handshake.
// ---------------------------------------------------------------------------
interface pft_stream_if #(parameter type word_type = logic) ();
   logic     valid;
   logic     ready;
   word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hdl/pft_parser.sv]
// ---------------------------------------------------------------------------
// pft_parser: per-byte frame parser
// Extracts header fields and runs the PNG, HTTP and IEND matchers; hands a
// frame summary up on the last word.
// ---------------------------------------------------------------------------
module pft_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  logic [7:0]  data_byte,
   input  logic        last_byte,
   output logic [16:0] len,
   output logic [5:0]  ip_len,
   output logic [5:0]  tcp_len,
   output logic [31:0] seq,
   output logic [31:0] ack,
   output logic        png_found,
   output logic [15:0] png_pos,
   output logic        sig_ok,
   output logic        http_ok,
   output logic        iend_tail
);
   import pft_pkg::*;

   logic [16:0] pos_ff, pos_in;
   logic [5:0]  ip_ff, ip_in, tcp_ff, tcp_in;
   logic [31:0] seq_ff, seq_in, ack_ff, ack_in;
   logic        png_ff, png_in;
   logic [15:0] png_pos_ff, png_pos_in;
   logic [3:0]  sig_ff, sig_in;
   logic [2:0]  http_ff, http_in;
   logic [1:0]  iend_ff, iend_in;
   logic        iendf_ff, iendf_in;
   logic [16:0] iendp_ff, iendp_in;

   logic        room;
   logic [16:0] p, t, rel;

   always_comb begin
      room = pos_ff < 17'(MAX_FRAME_BYTES);
      p    = pos_ff;
      t    = 17'(ETH_BYTES) + 17'(ip_ff);
      rel  = p - t;
      pos_in = pos_ff; ip_in = ip_ff; tcp_in = tcp_ff; seq_in = seq_ff; ack_in = ack_ff;
      png_in = png_ff; png_pos_in = png_pos_ff; sig_in = sig_ff; http_in = http_ff;
      iend_in = iend_ff; iendf_in = iendf_ff; iendp_in = iendp_ff;
      if (room) begin
         pos_in = pos_ff + 17'd1;
         if (p == 17'(ETH_BYTES)) ip_in = {data_byte[3:0], 2'b00};
         if (p > 17'(ETH_BYTES)) begin
            if (p >= t + 17'd4 && p < t + 17'd8) seq_in = {seq_ff[23:0], data_byte};
            if (p >= t + 17'd8 && p < t + 17'd12) begin
               case (rel[1:0])
                  2'd0:    ack_in[7:0]   = ack_ff[7:0]   | data_byte;
                  2'd1:    ack_in[15:8]  = ack_ff[15:8]  | data_byte;
                  2'd2:    ack_in[23:16] = ack_ff[23:16] | data_byte;
                  default: ack_in[31:24] = ack_ff[31:24] | data_byte;
               endcase
            end
            if (p == t + 17'd12) tcp_in = {data_byte[7:4], 2'b00};
            if (p > t + 17'd12 && p >= t + 17'(tcp_ff)) begin
               if (!png_ff) begin
                  if (data_byte == 8'h89) begin
                     png_in = 1'b1; png_pos_in = p[15:0]; sig_in = 4'd1;
                  end
               end else if (sig_ff >= 4'd1 && sig_ff < SIG_LEN) begin
                  sig_in = (data_byte == sig_byte(sig_ff[2:0])) ? sig_ff + 4'd1 : SIG_FAILED;
               end
               if (http_ff < HTTP_LEN) begin
                  if (data_byte == http_byte(http_ff)) http_in = http_ff + 3'd1;
                  else http_in = (data_byte == http_byte(3'd0)) ? 3'd1 : 3'd0;
               end
            end
         end
         if (data_byte == iend_byte(iend_ff)) begin
            if (iend_ff == 2'd3) begin
               iendf_in = 1'b1; iendp_in = p; iend_in = 2'd0;
            end else iend_in = iend_ff + 2'd1;
         end else iend_in = (data_byte == iend_byte(2'd0)) ? 2'd1 : 2'd0;
      end
      // summary as seen after this word
      len       = pos_in;
      ip_len    = ip_in;
      tcp_len   = tcp_in;
      seq       = seq_in;
      ack       = ack_in;
      png_found = png_in;
      png_pos   = png_pos_in;
      sig_ok    = png_in && sig_in == SIG_LEN;
      http_ok   = http_in >= HTTP_LEN;
      iend_tail = iendf_in && (iendp_in + 17'd5 >= pos_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; ip_ff <= '0; tcp_ff <= '0; seq_ff <= '0; ack_ff <= '0;
         png_ff <= 1'b0; png_pos_ff <= '0; sig_ff <= '0; http_ff <= '0;
         iend_ff <= '0; iendf_ff <= 1'b0; iendp_ff <= '0;
      end else if (take) begin
         if (last_byte) begin
            // clear for the next frame
            pos_ff <= '0; ip_ff <= '0; tcp_ff <= '0; seq_ff <= '0; ack_ff <= '0;
            png_ff <= 1'b0; png_pos_ff <= '0; sig_ff <= '0; http_ff <= '0;
            iend_ff <= '0; iendf_ff <= 1'b0; iendp_ff <= '0;
         end else begin
            pos_ff <= pos_in; ip_ff <= ip_in; tcp_ff <= tcp_in; seq_ff <= seq_in;
            ack_ff <= ack_in; png_ff <= png_in; png_pos_ff <= png_pos_in;
            sig_ff <= sig_in; http_ff <= http_in; iend_ff <= iend_in;
            iendf_ff <= iendf_in; iendp_ff <= iendp_in;
         end
      end
   end
endmodule

[hdl/pft_flow_cell.sv]
// ---------------------------------------------------------------------------
// pft_flow_cell: one slot of the flow table
// Holds one entry; compares its ack and shifts from its upper neighbor on
// delete.
// ---------------------------------------------------------------------------
module pft_flow_cell (
   input  logic                     clock,
   input  logic                     write,      // table update this cycle
   input  logic                     is_tail,    // this slot receives an append
   input  pft_pkg::flow_cmd_type    cmd,
   input  logic                     is_hit,
   input  logic                     shift,      // slot lies at or above deleted entry
   input  pft_pkg::flow_entry_type  upper,
   input  logic [31:0]              key,
   output pft_pkg::flow_entry_type  entry,
   output logic                     match
);
   import pft_pkg::*;

   flow_entry_type ent_ff, ent_in;

   // a slot just appended this frame matches through its new contents
   always_comb begin
      ent_in = ent_ff;
      if (cmd.open && is_tail) ent_in = cmd.new_entry;
      if (cmd.adv && is_hit) ent_in.next_seq = ent_in.next_seq + 32'(cmd.step);
      if (cmd.del && shift) ent_in = upper;
   end

   assign entry = (cmd.open && is_tail) ? cmd.new_entry : ent_ff;
   assign match = entry.ack == key;

   always_ff @(posedge clock) begin
      if (write) ent_ff <= ent_in;
   end
endmodule

[hdl/png_flow_packet_tracker.sv]
// ---------------------------------------------------------------------------
// png_flow_packet_tracker: top level
// Byte-stream frame tracker with a chained flow table.
// ---------------------------------------------------------------------------
// Takes one frame byte per cycle with no gaps needed; the result word for the
// byte marked last is held in an output register, or while that is stalled in
// a skid stage, and input stalls only while both of them hold a word. The
// flow table is a row of FLOW_ENTRIES cells, each compared in parallel at
// frame end and shifted toward the head when an entry is removed; the first
// match in insertion order wins through a priority pick over the row.
module png_flow_packet_tracker (
   input  logic        clock,
   input  logic        reset,
   pft_stream_if.sink   req,
   pft_stream_if.source rsp,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);
   import pft_pkg::*;

   logic [15:0] seq_step_ff, min_pay_ff;
   logic [31:0] fcount_ff;
   logic [FLOW_CNT_W-1:0] count_ff, count_in;

   rsp_word_type out_ff, skid_ff, res;
   logic out_v_ff, skid_v_ff;

   logic take;
   assign req.ready = !skid_v_ff;
   assign take = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_step_ff <= SEQ_STEP_RESET;
         min_pay_ff  <= MIN_PAYLOAD_RESET;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_SEQ_STEP:    seq_step_ff <= csr_data;
            CSR_MIN_PAYLOAD: min_pay_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   logic [16:0] len;
   logic [5:0]  ip_len, tcp_len;
   logic [31:0] seq, ack;
   logic        png_found, sig_ok, http_ok, iend_tail;
   logic [15:0] png_pos;

   pft_parser u_parser (
      .clock, .reset, .take,
      .data_byte(req.data.data_byte), .last_byte(req.data.last_byte),
      .len, .ip_len, .tcp_len, .seq, .ack, .png_found, .png_pos,
      .sig_ok, .http_ok, .iend_tail
   );

   // frame-end decision
   logic finish;
   assign finish = take && req.data.last_byte;

   logic [17:0] pay_start, limit;
   logic        hdr_ok, want_flow, do_open;
   logic [31:0] fc_next;
   flow_cmd_type cmd;
   flow_entry_type cells [FLOW_ENTRIES];
   logic [FLOW_ENTRIES-1:0] match_v, valid_v;
   logic        found;
   logic [FLOW_IDX_W-1:0] hit_idx;
   flow_entry_type hit_e;

   always_comb begin
      cmd       = '0;
      pay_start = 18'(ETH_BYTES) + 18'(ip_len) + 18'(tcp_len);
      limit     = pay_start + 18'(min_pay_ff);
      fc_next   = fcount_ff + 32'd1;
      hdr_ok    = 7'(ip_len) >= MIN_HDR && 7'(tcp_len) >= MIN_HDR && 18'(len) > limit;
      want_flow = hdr_ok && png_found && http_ok;
      do_open   = want_flow && sig_ok && (32'(count_ff) < 32'(FLOW_ENTRIES));
      cmd.open  = do_open;
      cmd.new_entry.ack      = ack;
      cmd.new_entry.next_seq = seq;
      cmd.new_entry.id       = fc_next + ack;
      cmd.step  = seq_step_ff;
   end

   logic [FLOW_CNT_W-1:0] eff_count;
   assign eff_count = do_open ? count_ff + FLOW_CNT_W'(1) : count_ff;

   always_comb begin
      found = 1'b0; hit_idx = '0;
      for (int i = FLOW_ENTRIES - 1; i >= 0; i--) begin
         valid_v[i] = 32'(i) < 32'(eff_count);
         if (valid_v[i] && match_v[i]) begin
            found = 1'b1; hit_idx = FLOW_IDX_W'(i);
         end
      end
      hit_e = cells[hit_idx];
   end

   logic seq_hit, del;
   assign seq_hit = hdr_ok && found && seq == hit_e.next_seq;
   assign del     = seq_hit && iend_tail;

   flow_cmd_type cmd_f;
   always_comb begin
      cmd_f     = cmd;
      cmd_f.adv = seq_hit;
      cmd_f.del = del;
   end

   assign count_in = del ? eff_count - FLOW_CNT_W'(1) : eff_count;

   for (genvar g = 0; g < FLOW_ENTRIES; g++) begin : g_cell
      flow_entry_type up;
      if (g == FLOW_ENTRIES - 1) begin : g_top
         assign up = cells[g];
      end else begin : g_mid
         assign up = cells[g+1];
      end
      pft_flow_cell u_cell (
         .clock, .write(finish),
         .is_tail(FLOW_CNT_W'(g) == count_ff),
         .cmd(cmd_f),
         .is_hit(FLOW_IDX_W'(g) == hit_idx && found),
         .shift(FLOW_IDX_W'(g) >= hit_idx),
         .upper(up), .key(ack),
         .entry(cells[g]), .match(match_v[g])
      );
   end

   always_comb begin
      res = '0;
      if (7'(ip_len) < MIN_HDR) res.status = ST_BAD_IP;
      else if (7'(tcp_len) < MIN_HDR) res.status = ST_BAD_TCP;
      else if (!hdr_ok) res.status = ST_TOO_SMALL;
      else begin
         res.sig_rejected = want_flow && !sig_ok;
         res.table_full   = want_flow && sig_ok && !do_open;
         res.flow_started = do_open;
         if (!found) res.status = ST_UNTRACKED;
         else if (!seq_hit) begin
            res.status = ST_SEQ_MISS; res.file_id = hit_e.id;
         end else begin
            res.status = ST_WRITE; res.file_id = hit_e.id;
            res.write_offset = (want_flow && sig_ok) ? png_pos : pay_start[15:0];
            res.write_length = 16'(len) - res.write_offset;
            res.flow_ended   = del;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fcount_ff <= 32'd1; count_ff <= '0;
      end else if (finish) begin
         fcount_ff <= fc_next; count_ff <= count_in;
      end
   end

   // output register plus skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0; skid_v_ff <= 1'b0;
      end else begin
         if (!out_v_ff || rsp.ready) begin
            if (skid_v_ff) begin
               out_v_ff <= 1'b1; skid_v_ff <= 1'b0;
            end else out_v_ff <= finish;
         end else if (finish) skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp.ready) out_ff <= skid_v_ff ? skid_ff : res;
      if (finish && out_v_ff && !rsp.ready) skid_ff <= res;
   end

   assign rsp.valid = out_v_ff;
   assign rsp.data  = out_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(FLOW_ENTRIES)) else $error("flow count overflow");
   a_skid_only_stalled: assert property (@(posedge clock) disable iff (reset)
      skid_v_ff |-> out_v_ff) else $error("skid full with empty output");
   a_end_needs_write: assert property (@(posedge clock) disable iff (reset)
      (finish && del) |-> seq_hit) else $error("delete without sequence hit");
endmodule

[dv/pft_tb_pkg.sv]
// ---------------------------------------------------------------------------
// pft_tb_pkg: frame tracker scoreboard
// Predicts the result word of each frame from the accepted bytes and checks
// the words that leave the block, in order.
// ---------------------------------------------------------------------------
package pft_tb_pkg;
   import pft_pkg::*;

   class frame_tracker_scoreboard;
      // configuration copy
      logic [15:0] seq_step;
      logic [15:0] min_payload;
      // per-frame state
      int unsigned pos, ip_len, tcp_len;
      logic [31:0] seq, ack;
      bit          png_found, iend_found;
      int unsigned png_pos, sig_prog, http_prog, iend_prog, iend_pos;
      logic [31:0] frame_count;
      // flow table
      logic [31:0] tbl_ack[$];
      logic [31:0] tbl_seq[$];
      logic [31:0] tbl_id[$];
      rsp_word_type pending_results[$];
      int mismatches, results_checked;
      int status_seen[6];
      int opened, closed, refused;

      function new();
         seq_step = SEQ_STEP_RESET;
         min_payload = MIN_PAYLOAD_RESET;
         frame_count = 1;
         clear_frame();
      endfunction

      function void clear_frame();
         pos = 0; ip_len = 0; tcp_len = 0; seq = 0; ack = 0;
         png_found = 0; iend_found = 0; png_pos = 0; sig_prog = 0;
         http_prog = 0; iend_prog = 0; iend_pos = 0;
      endfunction

      function void write_csr(csr_index_type idx, logic [15:0] val);
         if (idx == CSR_SEQ_STEP) seq_step = val;
         else min_payload = val;
      endfunction

      function void scan_payload(int unsigned p, logic [7:0] b);
         if (!png_found) begin
            if (b == sig_byte(0)) begin
               png_found = 1; png_pos = p; sig_prog = 1;
            end
         end else if (sig_prog >= 1 && sig_prog < SIG_LEN) begin
            if (b == sig_byte(sig_prog[2:0])) sig_prog++;
            else sig_prog = SIG_FAILED;
         end
         if (http_prog < HTTP_LEN) begin
            if (b == http_byte(http_prog[2:0])) http_prog++;
            else http_prog = (b == http_byte(0)) ? 1 : 0;
         end
      endfunction

      function void scan_byte(int unsigned p, logic [7:0] b);
         int unsigned t;
         t = ETH_BYTES + ip_len;
         if (p == ETH_BYTES) ip_len = b[3:0] * 4;
         if (p > ETH_BYTES) begin
            if (p >= t + 4 && p < t + 8) seq = {seq[23:0], b};
            if (p >= t + 8 && p < t + 12) ack |= 32'(b) << (8 * (p - t - 8));
            if (p == t + 12) tcp_len = b[7:4] * 4;
            if (p > t + 12 && p >= t + tcp_len) scan_payload(p, b);
         end
         if (b == iend_byte(iend_prog[1:0])) begin
            if (iend_prog >= 3) begin
               iend_found = 1; iend_pos = p; iend_prog = 0;
            end else iend_prog++;
         end else iend_prog = (b == iend_byte(0)) ? 1 : 0;
      endfunction

      function void close_frame();
         rsp_word_type r;
         int unsigned len, pay, start;
         int idx;
         r = '0;
         len = pos;
         pay = ETH_BYTES + ip_len + tcp_len;
         frame_count++;
         if (ip_len < MIN_HDR) r.status = ST_BAD_IP;
         else if (tcp_len < MIN_HDR) r.status = ST_BAD_TCP;
         else if (len <= pay + min_payload) r.status = ST_TOO_SMALL;
         else begin
            start = pay;
            if (png_found && http_prog >= HTTP_LEN) begin
               if (sig_prog != SIG_LEN) r.sig_rejected = 1;
               else if (tbl_ack.size() >= FLOW_ENTRIES) begin
                  r.table_full = 1; start = png_pos; refused++;
               end else begin
                  tbl_ack.insert(tbl_ack.size(), ack);
                  tbl_seq.insert(tbl_seq.size(), seq);
                  tbl_id.insert(tbl_id.size(), frame_count + ack);
                  r.flow_started = 1; start = png_pos; opened++;
               end
            end
            idx = -1;
            foreach (tbl_ack[i])
               if (idx < 0 && tbl_ack[i] == ack) idx = i;
            if (idx < 0) r.status = ST_UNTRACKED;
            else if (seq != tbl_seq[idx]) begin
               r.status = ST_SEQ_MISS; r.file_id = tbl_id[idx];
            end else begin
               r.status = ST_WRITE; r.file_id = tbl_id[idx];
               tbl_seq[idx] += seq_step;
               r.write_offset = start[15:0];
               r.write_length = 16'(len - start);
               if (iend_found && iend_pos + 5 >= len) begin
                  tbl_ack.delete(idx); tbl_seq.delete(idx); tbl_id.delete(idx);
                  r.flow_ended = 1; closed++;
               end
            end
         end
         status_seen[r.status]++;
         pending_results.insert(pending_results.size(), r);
         clear_frame();
      endfunction

      // note one accepted frame byte
      function void take_word(req_word_type w);
         if (pos < MAX_FRAME_BYTES) begin
            scan_byte(pos, w.data_byte);
            pos++;
         end
         if (w.last_byte) close_frame();
      endfunction

      function void check_result(rsp_word_type got);
         rsp_word_type want;
         results_checked++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %p", got);
            return;
         end
         want = pending_results.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result %0d mismatch: expected %p, got %p",
                        results_checked, want, got);
         end
      endfunction
   endclass
endpackage

[dv/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top: frame tracker regression
// Streams directed and random Ethernet/IPv4/TCP frames with random gaps and
// result stalls, changes the registers between phases and checks every
// result word against the scoreboard prediction.
// ---------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pft_pkg::*;
   import pft_tb_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write = 0;
   logic        csr_index = 0;
   logic [15:0] csr_data = 0;
   int unsigned cycle_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned frames_sent = 0;
   bit          sending = 1;

   pft_stream_if #(.word_type(req_word_type)) req_if ();
   pft_stream_if #(.word_type(rsp_word_type)) rsp_if ();

   png_flow_packet_tracker dut (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   frame_tracker_scoreboard frame_board = new();

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   initial begin
      req_if.valid = 0;
      req_if.data = '0;
      rsp_if.ready = 0;
   end

   // sample both channels on the rising edge
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && req_if.valid && req_if.ready) frame_board.take_word(req_if.data);
      if (!reset && rsp_if.valid && rsp_if.ready) frame_board.check_result(rsp_if.data);
   end

   // result stalls: random wait per word, with calm stretches
   initial begin
      int unsigned hold;
      @(negedge clock);
      while (1) begin
         hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         repeat (hold) begin
            rsp_if.ready <= 0;
            @(negedge clock);
         end
         rsp_if.ready <= 1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_word(logic [7:0] b, bit last, bit calm);
      int unsigned gap;
      gap = calm ? 0 : $urandom_range(0, 11);
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (gap > 0) begin
         req_if.valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1;
      req_if.data <= '{data_byte: b, last_byte: last};
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(logic [7:0] f[$], bit calm);
      foreach (f[i]) send_word(f[i], i == f.size() - 1, calm);
      frames_sent++;
   endtask

   // idle the input, then wait for every predicted word to come back
   task automatic drain();
      req_if.valid <= 0;
      while (frame_board.pending_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] val);
      drain();
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 0;
      frame_board.write_csr(idx, val);
   endtask

   function automatic void append_byte(ref logic [7:0] q[$], input logic [7:0] b);
      q.insert(q.size(), b);
   endfunction

   // build a frame; payload content supplied by caller
   function automatic void build_frame(ref logic [7:0] f[$], input int ihl, int thl,
                                       logic [31:0] seq, logic [31:0] ack,
                                       logic [7:0] pay[$]);
      f = {};
      repeat (14) append_byte(f, 8'($urandom));
      append_byte(f, {4'h4, 4'(ihl)});
      repeat (ihl * 4 - 1) append_byte(f, 8'($urandom));
      repeat (4) append_byte(f, 8'($urandom));
      for (int i = 3; i >= 0; i--) append_byte(f, seq[8*i +: 8]);
      for (int i = 0; i < 4; i++) append_byte(f, ack[8*i +: 8]);
      append_byte(f, {4'(thl), 4'($urandom)});
      repeat (thl * 4 - 13) append_byte(f, 8'($urandom));
      foreach (pay[i]) append_byte(f, pay[i]);
   endfunction

   function automatic void png_payload(ref logic [7:0] pay[$], input int pad,
                                       bit good_sig, bit http, bit iend_tail);
      logic [7:0] sig[8] = '{8'h89, 8'h50, 8'h4e, 8'h47, 8'h0d, 8'h0a, 8'h1a, 8'h0a};
      logic [7:0] hp[6] = '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2f, 8'h31};
      pay = {};
      if (http) foreach (hp[i]) append_byte(pay, hp[i]);
      repeat ($urandom_range(0, 4)) append_byte(pay, 8'($urandom_range(0, 127)));
      foreach (sig[i]) append_byte(pay, (!good_sig && i == 3) ? 8'h00 : sig[i]);
      repeat (pad) append_byte(pay, 8'($urandom));
      if (iend_tail) begin
         append_byte(pay, 8'h49); append_byte(pay, 8'h45);
         append_byte(pay, 8'h4e); append_byte(pay, 8'h44);
         repeat ($urandom_range(0, 4)) append_byte(pay, 8'($urandom));
      end
   endfunction

   logic [31:0] flow_acks[8];
   logic [31:0] flow_seqs[8];
   bit          flow_live[8];

   task automatic random_frame(bit calm);
      logic [7:0] f[$];
      logic [7:0] pay[$];
      int sel, k, ihl, thl;
      sel = $urandom_range(0, 99);
      k = $urandom_range(0, 7);
      ihl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 6);
      thl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(5, 6);
      if (sel < 25 || !flow_live[k]) begin
         // open (or try to open) a flow
         flow_acks[k] = $urandom;
         flow_seqs[k] = $urandom;
         png_payload(pay, $urandom_range(0, 10), $urandom_range(0, 7) != 0,
                     $urandom_range(0, 7) != 0, 0);
         build_frame(f, ihl, thl, flow_seqs[k], flow_acks[k], pay);
         flow_live[k] = 1;
         flow_seqs[k] += frame_board.seq_step;
      end else if (sel < 85) begin
         // continue a flow, sometimes with a wrong seq or closing IEND
         pay = {};
         repeat ($urandom_range(4, 24)) append_byte(pay, 8'($urandom));
         if ($urandom_range(0, 5) == 0) begin
            append_byte(pay, 8'h49); append_byte(pay, 8'h45);
            append_byte(pay, 8'h4e); append_byte(pay, 8'h44);
            repeat ($urandom_range(0, 5)) append_byte(pay, 8'($urandom));
         end
         if ($urandom_range(0, 7) == 0)
            build_frame(f, ihl, thl, $urandom, flow_acks[k], pay);
         else begin
            build_frame(f, ihl, thl, flow_seqs[k], flow_acks[k], pay);
            flow_seqs[k] += frame_board.seq_step;
         end
      end else begin
         // noise
         repeat ($urandom_range(1, 50)) append_byte(f, 8'($urandom));
      end
      send_frame(f, calm);
   endtask

   initial begin
      logic [7:0] f[$];
      logic [7:0] pay[$];
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: short frames and header extremes
      f = {8'hff}; send_frame(f, 0);
      f = {}; repeat (14) append_byte(f, 8'h00); send_frame(f, 0);
      pay = {}; build_frame(f, 4, 5, 0, 0, pay); send_frame(f, 0);
      build_frame(f, 15, 4, 0, 0, pay); send_frame(f, 0);
      build_frame(f, 5, 15, 32'hffffffff, 32'hffffffff, pay); send_frame(f, 0);
      repeat (32) append_byte(pay, 8'hff);
      build_frame(f, 5, 5, 1, 2, pay); send_frame(f, 0);

      // hold off until every result is back, then drop the payload floor
      drain();
      write_csr(CSR_MIN_PAYLOAD, 16'd0);
      // open, write, mismatch, close
      png_payload(pay, 2, 1, 1, 0);
      build_frame(f, 5, 5, 32'h1000, 32'hdeadbeef, pay); send_frame(f, 0);
      png_payload(pay, 2, 0, 1, 0);
      build_frame(f, 5, 5, 32'h55, 32'h1234, pay); send_frame(f, 0);
      build_frame(f, 5, 5, 32'h1000 + 1448, 32'hdeadbeef, pay); send_frame(f, 0);
      build_frame(f, 5, 5, 32'h7, 32'hdeadbeef, pay); send_frame(f, 1);
      png_payload(pay, 2, 1, 0, 1);
      build_frame(f, 5, 5, 32'h1000 + 2896, 32'hdeadbeef, pay); send_frame(f, 1);
      // a signature cut off by the frame end
      pay = {}; repeat (4) append_byte(pay, 8'h20);
      append_byte(pay, 8'h48); append_byte(pay, 8'h54); append_byte(pay, 8'h54);
      append_byte(pay, 8'h50); append_byte(pay, 8'h2f); append_byte(pay, 8'h31);
      append_byte(pay, 8'h89); append_byte(pay, 8'h50);
      build_frame(f, 5, 5, 0, 32'h9, pay); send_frame(f, 0);

      write_csr(CSR_SEQ_STEP, 16'd0);
      repeat (5) random_frame($urandom_range(0, 3) == 0);
      write_csr(CSR_SEQ_STEP, 16'hffff);
      write_csr(CSR_MIN_PAYLOAD, 16'd16);
      repeat (4) random_frame($urandom_range(0, 3) == 0);
      write_csr(CSR_MIN_PAYLOAD, 16'hffff);
      repeat (2) random_frame(0);
      write_csr(CSR_SEQ_STEP, 16'd1448);
      write_csr(CSR_MIN_PAYLOAD, 16'd8);
      repeat (3) random_frame($urandom_range(0, 3) == 0);
      sending = 0;
      drain();
      $display("covered %0d frames, %0d words; status counts %p",
               frames_sent, bytes_sent, frame_board.status_seen);
      $display("flows opened %0d, closed %0d, refused %0d",
               frame_board.opened, frame_board.closed, frame_board.refused);
      if (frame_board.mismatches == 0 && frame_board.pending_results.size() == 0)
         $display("png_flow_packet_tracker regression: pass");
      else
         $display("png_flow_packet_tracker regression: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (cycle_count == 200000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("png_flow_packet_tracker regression: fail");
         $finish;
      end
   end
endmodule
